FILE: hdl/bft_pkg.sv
package bft_pkg;

  // Store geometry
  localparam int MAX_BITS = 1024;
  localparam int IDX_W    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int MOD_W    = $clog2(MAX_BITS + 1);

  // Configuration register
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] BIT_COUNT_RST = CFG_W'(1024);
  localparam int CMP_W = (CFG_W > MOD_W) ? CFG_W : MOD_W;

  // Field widths
  localparam int KEY_W = 32;
  localparam int DIV_W = 64;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // Hash constants
  localparam logic [KEY_W-1:0] MULT_KNUTH = 32'd2654435761;
  localparam logic [KEY_W-1:0] MULT_POLY  = 32'd97;
  localparam logic [KEY_W-1:0] ADD_POLY   = 32'd13;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    PROBE_ID    = 2'd0,
    PROBE_KNUTH = 2'd1,
    PROBE_POLY  = 2'd2
  } probe_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
  } store_req_t;

endpackage

FILE: hdl/bft_hash.sv
module bft_hash (
  input  logic                        clk,
  input  logic                        load,
  input  logic [bft_pkg::KEY_W-1:0]   key,
  input  bft_pkg::probe_t             probe,
  output logic [bft_pkg::DIV_W-1:0]   hash
);

  logic [bft_pkg::KEY_W-1:0] mul;
  logic [bft_pkg::KEY_W-1:0] add;
  logic [bft_pkg::DIV_W-1:0] prod;
  logic [bft_pkg::DIV_W-1:0] corr;
  logic [bft_pkg::DIV_W-1:0] hash_r;

  always_comb begin
    case (probe)
      bft_pkg::PROBE_ID: begin
        mul = bft_pkg::KEY_W'(1);
        add = '0;
      end
      bft_pkg::PROBE_KNUTH: begin
        mul = bft_pkg::MULT_KNUTH;
        add = '0;
      end
      bft_pkg::PROBE_POLY: begin
        mul = bft_pkg::MULT_POLY;
        add = bft_pkg::ADD_POLY;
      end
      default: begin
        mul = '0;
        add = '0;
      end
    endcase
  end

  // Unsigned 32x32 product, then take off mul * 2^32 for a negative key
  assign prod = bft_pkg::DIV_W'(key) * bft_pkg::DIV_W'(mul);
  assign corr = key[bft_pkg::KEY_W-1] ? {mul, {bft_pkg::KEY_W{1'b0}}} : '0;

  always_ff @(posedge clk) begin
    if (load) begin
      hash_r <= prod + bft_pkg::DIV_W'(add) - corr;
    end
  end

  assign hash = hash_r;

endmodule

FILE: hdl/bft_div.sv
module bft_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bft_pkg::DIV_W-1:0]   dividend,
  input  logic [bft_pkg::MOD_W-1:0]   modulus,
  output logic [bft_pkg::MOD_W-1:0]   rem,
  output bft_pkg::div_stat_t          stat
);

  logic [bft_pkg::DIV_W-1:0] num_r;
  logic [bft_pkg::MOD_W-1:0] rem_r;
  logic [bft_pkg::CNT_W-1:0] cnt_r;
  logic                      done_r;
  logic [bft_pkg::MOD_W:0]   shifted;
  logic                      ge;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, num_r[bft_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= bft_pkg::CNT_W'(bft_pkg::DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - bft_pkg::CNT_W'(1);
        if (cnt_r == bft_pkg::CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[bft_pkg::DIV_W-2:0], 1'b0};
      rem_r <= ge ? bft_pkg::MOD_W'(shifted - {1'b0, modulus})
                  : shifted[bft_pkg::MOD_W-1:0];
    end
  end

  assign rem       = rem_r;
  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;

endmodule

FILE: hdl/bft_store.sv
module bft_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bft_pkg::store_req_t         req,
  output logic                        rd_bit,
  output logic                        clearing
);

  logic                      mem [bft_pkg::MAX_BITS];
  logic [bft_pkg::IDX_W-1:0] clr_idx_r;
  logic                      clearing_r;
  logic                      rd_r;

  // Sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + bft_pkg::IDX_W'(1);
      if (clr_idx_r == bft_pkg::IDX_W'(bft_pkg::MAX_BITS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= 1'b0;
    end else if (req.we) begin
      mem[req.addr] <= 1'b1;
    end
    rd_r <= mem[req.addr];
  end

  assign rd_bit   = rd_r;
  assign clearing = clearing_r;

endmodule

FILE: hdl/bloom_filter_three_hash_core.sv
// Sequence: each input word runs three probes in turn;
//   a probe is hash, start, remainder, probe, check. The result then waits
//   in ST_FIN until the output register is free.
// Acceptance: a new word is taken only after the previous one has left ST_FIN;
//   the 64-step serial remainder unit, run once per probe, sets the pace.
// Reset: synchronous active-low rst_n; after release the bit store is swept to
//   zero entry by entry over all MAX_BITS (1024) entries, during which no input word is accepted.
//   bit_count resets to 1024.
module bloom_filter_three_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic        in_tuser,   // [0] command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] found, [7:1] zero
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data    // bit_count
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_HASH   = 7'b0000010,
    ST_DSTART = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_PROBE  = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t                        st_r, st_nxt;
  bft_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [bft_pkg::KEY_W-1:0]     key_r, key_nxt;
  bft_pkg::probe_t               probe_r, probe_nxt;
  logic                          hit_r, hit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [bft_pkg::CFG_W-1:0]     bit_count_r;

  logic [bft_pkg::CMP_W-1:0]     bc_ext;
  logic [bft_pkg::MOD_W-1:0]     eff_mod;
  logic                          hash_ld;
  logic [bft_pkg::DIV_W-1:0]     hash;
  logic                          div_start;
  logic [bft_pkg::MOD_W-1:0]     rem;
  bft_pkg::div_stat_t            div_st;
  bft_pkg::store_req_t           store_req;
  logic                          rd_bit;
  logic                          clearing;
  logic                          in_acc;

  // Configuration: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r <= bft_pkg::BIT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      bit_count_r <= cfg_data;
    end
  end

  // Effective modulus: treat zero as one, clamp to the store size
  assign bc_ext = bft_pkg::CMP_W'(bit_count_r);

  always_comb begin
    if (bc_ext == '0) begin
      eff_mod = bft_pkg::MOD_W'(1);
    end else if (bc_ext > bft_pkg::CMP_W'(bft_pkg::MAX_BITS)) begin
      eff_mod = bft_pkg::MOD_W'(bft_pkg::MAX_BITS);
    end else begin
      eff_mod = bft_pkg::MOD_W'(bc_ext);
    end
  end

  // Shared multiplier: one probe product per pass
  bft_hash u_hash (
    .clk   (clk),
    .load  (hash_ld),
    .key   (key_r),
    .probe (probe_r),
    .hash  (hash)
  );

  // Shared serial remainder unit: one bit per cycle
  bft_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (hash),
    .modulus  (eff_mod),
    .rem      (rem),
    .stat     (div_st)
  );

  bft_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (store_req),
    .rd_bit   (rd_bit),
    .clearing (clearing)
  );

  assign in_tready = (st_r == ST_IDLE) && !clearing;
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer: hash, reduce, probe, three times per word
  always_comb begin
    st_nxt         = st_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    probe_nxt      = probe_r;
    hit_nxt        = hit_r;
    out_found_nxt  = out_found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    hash_ld        = 1'b0;
    div_start      = 1'b0;
    store_req.we   = 1'b0;
    store_req.addr = bft_pkg::IDX_W'(rem);

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = bft_pkg::cmd_t'(in_tuser);
          key_nxt   = in_tdata;
          probe_nxt = bft_pkg::PROBE_ID;
          hit_nxt   = 1'b1;
          st_nxt    = ST_HASH;
        end
      end
      ST_HASH: begin
        hash_ld = 1'b1;
        st_nxt  = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        st_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) begin
          st_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // set the bit on insert; the read data lands next cycle either way
        store_req.we = (cmd_r == bft_pkg::CMD_INSERT);
        st_nxt       = ST_CHECK;
      end
      ST_CHECK: begin
        if (cmd_r == bft_pkg::CMD_SEARCH) begin
          hit_nxt = hit_r && rd_bit;
        end
        case (probe_r)
          bft_pkg::PROBE_ID: begin
            probe_nxt = bft_pkg::PROBE_KNUTH;
            st_nxt    = ST_HASH;
          end
          bft_pkg::PROBE_KNUTH: begin
            probe_nxt = bft_pkg::PROBE_POLY;
            st_nxt    = ST_HASH;
          end
          default: begin
            st_nxt = ST_FIN;
          end
        endcase
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = (cmd_r == bft_pkg::CMD_SEARCH) && hit_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    probe_r     <= probe_nxt;
    hit_r       <= hit_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_found_r};

  // No word enters while the store sweep is running
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !clearing)
    else $error("input accepted during store clear");

  // Remainder is always below the modulus when the unit finishes
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (rem < eff_mod))
    else $error("remainder not reduced");

  // The remainder unit only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (st_r == ST_DIV))
    else $error("remainder done outside wait state");

  // The store is probed only after the remainder unit has gone idle
  a_probe_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PROBE) |-> !div_st.busy)
    else $error("probe while remainder unit busy");

endmodule

FILE: tb/tb_bloom_filter_three_hash_core.sv
module tb_bloom_filter_three_hash_core;

  // Tracks the membership store as the block should hold it and the replies
  // still owed, oldest first.
  class membership_tracker;
    bit                        store [bft_pkg::MAX_BITS];
    logic [bft_pkg::CFG_W-1:0] bit_count;
    logic                      awaited_found [$];
    bft_pkg::cmd_t             awaited_cmd [$];
    logic [bft_pkg::KEY_W-1:0] awaited_key [$];
    int                        failures;

    function new();
      foreach (store[i]) store[i] = 1'b0;
      bit_count = bft_pkg::BIT_COUNT_RST;
      failures  = 0;
    endfunction

    function void set_bit_count(logic [bft_pkg::CFG_W-1:0] value);
      bit_count = value;
    endfunction

    // Hash the key three ways, then insert or look up; queue the found flag.
    function void note_word(bft_pkg::cmd_t cmd, logic [bft_pkg::KEY_W-1:0] key);
      logic [63:0] wide_key;
      logic [63:0] modulus;
      logic [63:0] idx [3];
      logic        hit;
      wide_key = {{32{key[31]}}, key};
      // Zero acts as one; anything past the store clamps to its size.
      if (bit_count == '0)
        modulus = 64'd1;
      else if (bit_count > bft_pkg::MAX_BITS)
        modulus = 64'(bft_pkg::MAX_BITS);
      else
        modulus = 64'(bit_count);
      idx[0] = wide_key % modulus;
      idx[1] = (wide_key * 64'(bft_pkg::MULT_KNUTH)) % modulus;
      idx[2] = (wide_key * 64'(bft_pkg::MULT_POLY) + 64'(bft_pkg::ADD_POLY)) % modulus;
      hit = 1'b1;
      foreach (idx[i]) begin
        if (cmd == bft_pkg::CMD_INSERT)
          store[idx[i]] = 1'b1;
        else if (!store[idx[i]])
          hit = 1'b0;
      end
      awaited_found.insert(awaited_found.size(),
                           (cmd == bft_pkg::CMD_SEARCH) ? hit : 1'b0);
      awaited_cmd.insert(awaited_cmd.size(), cmd);
      awaited_key.insert(awaited_key.size(), key);
    endfunction

    function void check_reply(logic [7:0] word);
      logic                      want;
      bft_pkg::cmd_t             cmd;
      logic [bft_pkg::KEY_W-1:0] key;
      if (awaited_found.size() == 0) begin
        $display("%0t: unexpected result word %h, nothing outstanding", $time, word);
        failures++;
        return;
      end
      want = awaited_found.pop_front();
      cmd  = awaited_cmd.pop_front();
      key  = awaited_key.pop_front();
      if (word[0] !== want) begin
        $display("%0t: found mismatch (%s key %h): expected %0d, actual %0d",
                 $time, cmd.name(), key, want, word[0]);
        failures++;
      end
      if (word[7:1] !== 7'd0) begin
        $display("%0t: pad bits mismatch (%s key %h): expected %h, actual %h",
                 $time, cmd.name(), key, 7'd0, word[7:1]);
        failures++;
      end
    endfunction

    function int pending();
      return awaited_found.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [bft_pkg::KEY_W-1:0]  in_tdata;   // [31:0] key
  logic                       in_tuser;   // [0] command
  logic                       out_tvalid;
  logic                       out_tready;
  logic [7:0]                 out_tdata;  // [0] found, [7:1] zero
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [bft_pkg::CFG_W-1:0]  cfg_data;

  membership_tracker          tracker;
  logic [bft_pkg::KEY_W-1:0]  inserted_keys [$];
  int unsigned                send_idle_pct;
  int unsigned                recv_idle_pct;

  bloom_filter_three_hash_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Throttle the result side: drop tready at random, one decision per cycle.
  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check every result word on the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_reply(out_tdata);
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one word; entered and left at a falling edge. Hold tvalid high
  // between back-to-back words so it is never lowered and raised in one step.
  task automatic send_word(input bft_pkg::cmd_t cmd,
                           input logic [bft_pkg::KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_word(cmd, key);
    @(negedge clk);
  endtask

  // Drop tvalid and hold until every owed result word has come back.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Write bit_count while the block is idle; entered and left at a falling edge.
  task automatic write_bit_count(input logic [bft_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_bit_count(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mix full-range keys with small signed ones and keys near both extremes.
  function automatic logic [bft_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 4))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 64) - 32;
      3:       return 32'h8000_0000 + $urandom_range(0, 15);
      default: return 32'h7fff_ffff - $urandom_range(0, 15);
    endcase
  endfunction

  // Mostly inserts and lookups of keys already in the filter, so searches hit;
  // the rest are lookups of fresh keys and repeated inserts.
  task automatic send_random_word();
    int unsigned               pick;
    logic [bft_pkg::KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 40 || inserted_keys.size() == 0) begin
      key = pick_key();
      inserted_keys.insert(inserted_keys.size(), key);
      send_word(bft_pkg::CMD_INSERT, key);
    end else if (pick < 75) begin
      key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      send_word(bft_pkg::CMD_SEARCH, key);
    end else if (pick < 90) begin
      send_word(bft_pkg::CMD_SEARCH, pick_key());
    end else begin
      key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      send_word(bft_pkg::CMD_INSERT, key);
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_word();
  endtask

  initial begin
    tracker       = new();
    send_idle_pct = 20;
    recv_idle_pct = 60;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = bft_pkg::CMD_INSERT;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, key extremes, all-ones and alternating patterns.
    // The handshake absorbs the post-reset clearing sweep.
    send_word(bft_pkg::CMD_SEARCH, 32'h0000_0000);
    send_word(bft_pkg::CMD_INSERT, 32'h0000_0000);
    send_word(bft_pkg::CMD_SEARCH, 32'h0000_0000);
    send_word(bft_pkg::CMD_INSERT, 32'h7fff_ffff);
    send_word(bft_pkg::CMD_SEARCH, 32'h7fff_ffff);
    send_word(bft_pkg::CMD_INSERT, 32'h8000_0000);
    send_word(bft_pkg::CMD_SEARCH, 32'h8000_0000);
    send_word(bft_pkg::CMD_INSERT, 32'hffff_ffff);
    send_word(bft_pkg::CMD_SEARCH, 32'hffff_ffff);
    send_word(bft_pkg::CMD_SEARCH, 32'h0000_0001);
    send_word(bft_pkg::CMD_SEARCH, 32'h1234_5678);
    send_word(bft_pkg::CMD_INSERT, 32'h5555_5555);
    send_word(bft_pkg::CMD_SEARCH, 32'haaaa_aaaa);

    // Zero bit count folds every probe onto bit 0.
    write_bit_count(11'd0);
    send_word(bft_pkg::CMD_SEARCH, 32'h0000_1234);
    send_word(bft_pkg::CMD_INSERT, 32'hdead_beef);
    send_word(bft_pkg::CMD_SEARCH, 32'h8000_0000);

    // Largest register value clamps to the store size; old bits stay put.
    write_bit_count(11'h7ff);
    send_word(bft_pkg::CMD_SEARCH, 32'h0000_0000);
    send_word(bft_pkg::CMD_SEARCH, 32'h7fff_ffff);

    write_bit_count(11'd1);
    send_word(bft_pkg::CMD_SEARCH, 32'd77);
    send_word(bft_pkg::CMD_INSERT, 32'd77);

    // Random part, sender idling lightly and receiver heavily. Halfway
    // through, hold the sender until the pipeline has fully drained.
    write_bit_count(11'd7);
    run_random(45);
    wait_drained();
    run_random(45);

    write_bit_count(11'd1000);
    run_random(60);

    // Swap the throttling: sender mostly idle, receiver mostly ready.
    write_bit_count(11'd513);
    send_idle_pct = 60;
    recv_idle_pct = 20;
    run_random(100);

    // No idling on either side.
    write_bit_count(11'd1024);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(120);

    write_bit_count(11'd64);
    run_random(80);

    // Drain, then give stray result words time to show up.
    wait_drained();
    repeat (250) @(negedge clk);

    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
hdl/bft_pkg.sv
hdl/bft_hash.sv
hdl/bft_div.sv
hdl/bft_store.sv
hdl/bloom_filter_three_hash_core.sv
tb/tb_bloom_filter_three_hash_core.sv
